[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SPNS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next cycle.
`define SPNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPNS_ASSERT(lbl, clk, rst, prop, msg)
`define SPNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/spns_pkg.sv]
// ---------------------------------------------------------------------------
// spns_pkg
// Shared widths, default sizes and codes of the priority server.
// ---------------------------------------------------------------------------
package spns_pkg;

  localparam int CMD_W   = 1;
  localparam int ID_W    = 16;
  localparam int CLASS_W = 2;
  localparam int TIME_W  = 16;
  localparam int KIND_W  = 1;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_CLASSES_DEF = 4;

  localparam logic [CMD_W-1:0] CMD_ARRIVAL = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 1'b1;

  localparam logic [KIND_W-1:0] EV_ANSWERED = 1'b0;
  localparam logic [KIND_W-1:0] EV_DROPPED  = 1'b1;

endpackage

[rtl/core/spns_if.sv]
// ---------------------------------------------------------------------------
// spns channel interfaces
// Valid/ready channels for request and tick transactions and for results.
// ---------------------------------------------------------------------------
interface spns_in_if import spns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ID_W-1:0]    requester_id;
  logic [CLASS_W-1:0] priority_class;
  logic [TIME_W-1:0]  service_time;

  modport source (output valid, cmd, requester_id, priority_class, service_time,
                  input ready);
  modport sink   (input valid, cmd, requester_id, priority_class, service_time,
                  output ready);
endinterface

interface spns_out_if import spns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [ID_W-1:0]    served_id;
  logic [CLASS_W-1:0] served_class;

  modport source (output valid, event_kind, served_id, served_class, input ready);
  modport sink   (input valid, event_kind, served_id, served_class, output ready);
endinterface

[rtl/core/strict_priority_nonpreemptive_server.sv]
// ---------------------------------------------------------------------------
// strict_priority_nonpreemptive_server
// Per-class FIFOs in one queue memory feeding a single non-preemptive server.
// ---------------------------------------------------------------------------
// Each input transaction is either an arrival, which appends a requester id
// and service time to the FIFO of its class (or reports it as dropped when
// the FIFO is full or the class does not exist), or a tick, which counts the
// server's remaining busy time down and, once the server is free, dequeues
// the oldest request of the highest non-empty class and reports it as
// answered. An arrival, and a tick that dequeues nothing, are finished in the
// idle state; a tick that dequeues also passes through the read state, as the
// queue memory has a registered read port. When the result channel stalls,
// the block holds the finished result in its output register, keeps accepting
// transactions that produce none, and waits in a hold state only when a second
// result is ready before the first was taken. The queue memory holds
// NUM_CLASSES * QUEUE_DEPTH entries of id and service time and needs no
// clearing after reset: only entries counted by a fill count are read.
`include "assert_macros.svh"

module strict_priority_nonpreemptive_server
  import spns_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spns_in_if.sink   items,
  spns_out_if.source results
);

  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int EW    = TIME_W + ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  // Queue memory: service time in the upper half, requester id in the lower.
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_q;

  state_t             state;
  logic [TIME_W-1:0]  busy;
  logic [HW-1:0]      head [NUM_CLASSES];
  logic [FW-1:0]      fill [NUM_CLASSES];
  logic [CLASS_W-1:0] rd_class;
  logic [KIND_W-1:0]  pend_kind;
  logic [ID_W-1:0]    pend_id;
  logic [CLASS_W-1:0] pend_class;
  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [ID_W-1:0]    out_id;
  logic [CLASS_W-1:0] out_class;

  logic               accept;
  logic               is_arrival;
  logic               is_tick;
  logic [CW-1:0]      arr_cls;
  logic               arr_exists;
  logic [FW-1:0]      arr_fill;
  logic               arr_store;
  logic               arr_drop;
  logic [HW:0]        tail_sum;
  logic [HW-1:0]      tail;
  logic [AW-1:0]      wr_addr;
  logic               mem_we;
  logic [TIME_W-1:0]  busy_dec;
  logic [CW-1:0]      pick;
  logic               pick_found;
  logic [AW-1:0]      rd_addr;
  logic               mem_re;
  logic               out_free;
  logic               out_load;
  logic [KIND_W-1:0]  ld_kind;
  logic [ID_W-1:0]    ld_id;
  logic [CLASS_W-1:0] ld_class;
  logic               fill_over;

  // Input side: one transaction at a time, only in the idle state.
  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign is_arrival  = accept && (items.cmd == CMD_ARRIVAL);
  assign is_tick     = accept && (items.cmd == CMD_TICK);

  // Arrival path: the tail slot is head plus fill, wrapped once.
  assign arr_cls    = CW'(items.priority_class);
  assign arr_exists = int'(items.priority_class) < NUM_CLASSES;
  assign arr_fill   = arr_exists ? fill[arr_cls] : FW'(QUEUE_DEPTH);
  assign arr_store  = arr_exists && (arr_fill < FW'(QUEUE_DEPTH));
  assign arr_drop   = is_arrival && !arr_store;
  assign tail_sum   = (HW+1)'(head[arr_cls]) + (HW+1)'(arr_fill);
  assign tail       = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                      HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign wr_addr    = AW'(int'(arr_cls) * QUEUE_DEPTH) + AW'(tail);
  assign mem_we     = is_arrival && arr_store;

  // Tick path: count down first, then pick the highest non-empty class.
  assign busy_dec = (busy != '0) ? busy - 1'b1 : busy;

  always_comb begin
    pick       = '0;
    pick_found = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill[c] != '0) begin
        pick       = CW'(c);
        pick_found = 1'b1;
      end
    end
  end

  assign rd_addr = AW'(int'(pick) * QUEUE_DEPTH) + AW'(head[pick]);
  assign mem_re  = is_tick && (busy_dec == '0) && pick_found;

  // Output register loads when it is empty or being emptied this cycle.
  assign out_free = !out_valid || results.ready;

  always_comb begin
    out_load = 1'b0;
    ld_kind  = EV_ANSWERED;
    ld_id    = rd_q[ID_W-1:0];
    ld_class = rd_class;
    unique case (state)
      S_IDLE: begin
        out_load = arr_drop && out_free;
        ld_kind  = EV_DROPPED;
        ld_id    = items.requester_id;
        ld_class = items.priority_class;
      end
      S_READ: begin
        out_load = out_free;
      end
      S_EMIT: begin
        out_load = out_free;
        ld_kind  = pend_kind;
        ld_id    = pend_id;
        ld_class = pend_class;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {items.service_time, items.requester_id};
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        fill[c] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_kind  <= ld_kind;
        out_id    <= ld_id;
        out_class <= ld_class;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (mem_we) begin
            fill[arr_cls] <= fill[arr_cls] + 1'b1;
          end
          if (arr_drop && !out_free) begin
            // The output register is still occupied: park the drop report.
            pend_kind  <= EV_DROPPED;
            pend_id    <= items.requester_id;
            pend_class <= items.priority_class;
            state      <= S_EMIT;
          end
          if (is_tick) begin
            busy <= busy_dec;
          end
          if (mem_re) begin
            head[pick] <= (head[pick] == HW'(QUEUE_DEPTH - 1)) ? '0 : head[pick] + 1'b1;
            fill[pick] <= fill[pick] - 1'b1;
            rd_class   <= CLASS_W'(pick);
            state      <= S_READ;
          end
        end
        S_READ: begin
          // Read data is valid now; the server starts on this request.
          busy <= rd_q[EW-1:ID_W];
          if (out_free) begin
            state <= S_IDLE;
          end else begin
            pend_kind  <= EV_ANSWERED;
            pend_id    <= rd_q[ID_W-1:0];
            pend_class <= rd_class;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.event_kind   = out_kind;
  assign results.served_id    = out_id;
  assign results.served_class = out_class;

  always_comb begin
    fill_over = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill[c] > FW'(QUEUE_DEPTH)) begin
        fill_over = 1'b1;
      end
    end
  end

  `SPNS_ASSERT(a_fill_bound, clk, rst, !fill_over, "queue fill count above depth")
  `SPNS_ASSERT(a_no_overwrite, clk, rst, out_load |-> out_free, "result overwritten")
  `SPNS_ASSERT(a_answer_from_mem, clk, rst, (out_load && ld_kind == EV_ANSWERED) |-> (state == S_READ || state == S_EMIT), "answer without queue read")
  `SPNS_ASSERT_NEXT(a_fill_grow, clk, rst, mem_we, fill[$past(arr_cls)] == $past(arr_fill) + 1'b1, "stored arrival not counted")
  `SPNS_ASSERT_NEXT(a_busy_load, clk, rst, state == S_READ, busy == $past(rd_q[EW-1:ID_W]), "server time not loaded")

endmodule
